/* hdl/bqd_pkg.sv */
// bqd_pkg: shared constants and types of the biquad low-pass section
// fixed-point formats, register map, reset coefficients, sequencer states
// no dependencies
package bqd_pkg;

    localparam int SAMPLE_W_DEF = 16;
    localparam int COEF_W_DEF   = 16;

    // delay registers hold Q20.14 values
    localparam int DELAY_W   = 34;
    localparam int FRAC_BITS = 14;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // reset coefficients, signed Q2.14
    localparam int RST_B0 = 3384;
    localparam int RST_B1 = 6769;
    localparam int RST_B2 = 3384;
    localparam int RST_A1 = -6054;
    localparam int RST_A2 = 3208;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FB1,
        ST_FF2,
        ST_FB2
    } t_state;

endpackage

/* hdl/biquad_df2t_lowpass_filter.sv */
// biquad_df2t_lowpass_filter: second-order IIR section, direct form II transposed
// depends on: bqd_pkg, bqd_mac, bqd_cfg
//
// One filter item is worked in steps, one multiply each: the accept step, then
// the rounding, FB1, FF2 and FB2 steps, because all five products (b0*x, b1*x,
// a1*y, b2*x, a2*y) go through the single shared multiply-accumulate unit in
// turn. sample_out is registered in the rounding step that follows acceptance;
// a result still waiting on the output holds the sequencer at its rounding
// step; a new item is taken only in idle. A clear item zeroes both delay
// registers in its accept cycle and gives no result. Coefficients are signed
// Q2.14 at byte addresses 0 (b0), 4 (b1), 8 (b2), 12 (a1), 16 (a2), reset to
// a 10 Hz cutoff, 50 Hz sample-rate Butterworth low-pass; write them only
// while the block is idle. The output is round-half-up from Q.14 and
// saturated; delay registers saturate to 34 bits.
module biquad_df2t_lowpass_filter #(
    parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_W_DEF,
    parameter int COEF_WIDTH   = bqd_pkg::COEF_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bqd_pkg::ADDR_W-1:0]     paddr,
    input  logic [bqd_pkg::DATA_W-1:0]     pwdata,
    output logic [bqd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    import bqd_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int PW = SW + CW;
    localparam int AW = ((PW > DELAY_W) ? PW : DELAY_W) + 2;

    localparam logic signed [AW-1:0] Y_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [AW-1:0] D_MAX = {{(AW-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [AW-1:0] D_MIN = ~D_MAX;
    localparam logic signed [AW-1:0] HALF  = AW'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {CS_B0, CS_B1, CS_B2, CS_A1, CS_A2} t_coef_sel;
    typedef enum logic [1:0] {OS_IN, OS_X, OS_Y} t_opd_sel;
    typedef enum logic [1:0] {AS_ZERO, AS_D1, AS_D2, AS_ACC} t_add_sel;

    typedef struct packed {
        t_coef_sel coef;
        t_opd_sel  opd;
        t_add_sel  add;
        logic      sub;
    } t_mac_ctl;

    logic signed [CW-1:0]      w_b0, w_b1, w_b2, w_a1, w_a2;
    t_state                    r_state, n_state;
    t_mac_ctl                  w_ctl;
    logic                      r_out_valid;
    logic signed [DELAY_W-1:0] r_d1, r_d2;
    logic signed [SW-1:0]      r_x, r_y;
    logic signed [AW-1:0]      r_acc;
    logic signed [CW-1:0]      w_coef;
    logic signed [SW-1:0]      w_opd;
    logic signed [AW-1:0]      w_add;
    logic signed [AW-1:0]      w_sum;
    logic signed [AW-1:0]      w_rnd;
    logic signed [SW-1:0]      w_y;
    logic                      w_in_fire;
    logic                      w_round_go;

    function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [AW-1:0] v);
        logic signed [DELAY_W-1:0] res;
        if (v > D_MAX) begin
            res = D_MAX[DELAY_W-1:0];
        end else if (v < D_MIN) begin
            res = D_MIN[DELAY_W-1:0];
        end else begin
            res = v[DELAY_W-1:0];
        end
        return res;
    endfunction

    bqd_cfg #(.CW(CW)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_b0    (w_b0),
        .o_b1    (w_b1),
        .o_b2    (w_b2),
        .o_a1    (w_a1),
        .o_a2    (w_a2)
    );

    bqd_mac #(.SW(SW), .CW(CW), .AW(AW)) u_mac (
        .i_coef    (w_coef),
        .i_operand (w_opd),
        .i_addend  (w_add),
        .i_sub     (w_ctl.sub),
        .o_sum     (w_sum)
    );

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_in_fire    = i_in_valid & o_in_ready;
    // rounding step may only overwrite the output register once it is free
    assign w_round_go   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_y;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_fire && !i_func) n_state = ST_ROUND;
            ST_ROUND: if (w_round_go) n_state = ST_FB1;
            ST_FB1:   n_state = ST_FF2;
            ST_FF2:   n_state = ST_FB2;
            ST_FB2:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // mac schedule per step
    always_comb begin
        unique case (r_state)
            ST_IDLE:  w_ctl = '{coef: CS_B0, opd: OS_IN, add: AS_D1,   sub: 1'b0};
            ST_ROUND: w_ctl = '{coef: CS_B1, opd: OS_X,  add: AS_D2,   sub: 1'b0};
            ST_FB1:   w_ctl = '{coef: CS_A1, opd: OS_Y,  add: AS_ACC,  sub: 1'b1};
            ST_FF2:   w_ctl = '{coef: CS_B2, opd: OS_X,  add: AS_ZERO, sub: 1'b0};
            ST_FB2:   w_ctl = '{coef: CS_A2, opd: OS_Y,  add: AS_ACC,  sub: 1'b1};
            default:  w_ctl = '{coef: CS_B0, opd: OS_IN, add: AS_D1,   sub: 1'b0};
        endcase
    end

    always_comb begin
        unique case (w_ctl.coef)
            CS_B0:   w_coef = w_b0;
            CS_B1:   w_coef = w_b1;
            CS_B2:   w_coef = w_b2;
            CS_A1:   w_coef = w_a1;
            CS_A2:   w_coef = w_a2;
            default: w_coef = w_b0;
        endcase
        unique case (w_ctl.opd)
            OS_IN:   w_opd = i_sample_in;
            OS_X:    w_opd = r_x;
            OS_Y:    w_opd = r_y;
            default: w_opd = i_sample_in;
        endcase
        unique case (w_ctl.add)
            AS_ZERO: w_add = '0;
            AS_D1:   w_add = AW'(r_d1);
            AS_D2:   w_add = AW'(r_d2);
            AS_ACC:  w_add = r_acc;
            default: w_add = '0;
        endcase
    end

    // round half up out of Q.14, then saturate to the sample range
    always_comb begin
        w_rnd = (r_acc + HALF) >>> FRAC_BITS;
        if (w_rnd > Y_MAX) begin
            w_y = Y_MAX[SW-1:0];
        end else if (w_rnd < Y_MIN) begin
            w_y = Y_MIN[SW-1:0];
        end else begin
            w_y = w_rnd[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ROUND && w_round_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_fire && i_func) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end
            if (r_state == ST_FF2) begin
                r_d1 <= sat_delay(r_acc);
            end
            if (r_state == ST_FB2) begin
                r_d2 <= sat_delay(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && !i_func) begin
                    r_x   <= i_sample_in;
                    r_acc <= w_sum;
                end
            end
            ST_ROUND: begin
                if (w_round_go) begin
                    r_y   <= w_y;
                    r_acc <= w_sum;
                end
            end
            ST_FB1:  r_acc <= w_sum;
            ST_FF2:  r_acc <= w_sum;
            ST_FB2:  ;
            default: ;
        endcase
    end

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_func) |=> (r_state == ST_ROUND))
        else $error("filter item did not start the sequence");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_func) |=> (r_d1 == '0 && r_d2 == '0 && r_state == ST_IDLE))
        else $error("clear item left delay state or sequencer busy");

    a_result_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_ROUND))
        else $error("result raised outside the rounding step");

    a_round_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_out_valid && !i_out_ready) |=> (r_state == ST_ROUND))
        else $error("rounding step overran a waiting result");

endmodule

/* hdl/bqd_mac.sv */
// bqd_mac: shared signed multiply-accumulate unit
// sum = addend +/- coef * operand, sign-extended to the accumulator width
// depends on: nothing
module bqd_mac #(
    parameter int SW = 16,
    parameter int CW = 16,
    parameter int AW = 36
) (
    input  logic signed [CW-1:0] i_coef,
    input  logic signed [SW-1:0] i_operand,
    input  logic signed [AW-1:0] i_addend,
    input  logic                 i_sub,
    output logic signed [AW-1:0] o_sum
);

    localparam int PW = SW + CW;

    logic signed [PW-1:0] w_prod;
    logic signed [AW-1:0] w_prod_ext;

    assign w_prod     = i_coef * i_operand;
    assign w_prod_ext = AW'(w_prod);
    assign o_sum      = i_sub ? (i_addend - w_prod_ext) : (i_addend + w_prod_ext);

endmodule

/* hdl/bqd_cfg.sv */
// bqd_cfg: APB coefficient register file (b0, b1, b2, a1, a2)
// depends on: bqd_pkg
module bqd_cfg #(
    parameter int CW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bqd_pkg::ADDR_W-1:0] paddr,
    input  logic [bqd_pkg::DATA_W-1:0] pwdata,
    output logic [bqd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic signed [CW-1:0]       o_b0,
    output logic signed [CW-1:0]       o_b1,
    output logic signed [CW-1:0]       o_b2,
    output logic signed [CW-1:0]       o_a1,
    output logic signed [CW-1:0]       o_a2
);

    import bqd_pkg::*;

    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                 w_wr;
    t_reg_idx             w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= CW'(RST_B0);
            r_b1 <= CW'(RST_B1);
            r_b2 <= CW'(RST_B2);
            r_a1 <= CW'(RST_A1);
            r_a2 <= CW'(RST_A2);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_B0: r_b0 <= pwdata[CW-1:0];
                REG_B1: r_b1 <= pwdata[CW-1:0];
                REG_B2: r_b2 <= pwdata[CW-1:0];
                REG_A1: r_a1 <= pwdata[CW-1:0];
                REG_A2: r_a2 <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_B0:  prdata = DATA_W'(r_b0);
            REG_B1:  prdata = DATA_W'(r_b1);
            REG_B2:  prdata = DATA_W'(r_b2);
            REG_A1:  prdata = DATA_W'(r_a1);
            REG_A2:  prdata = DATA_W'(r_a2);
            default: prdata = '0;
        endcase
    end

    assign o_b0 = r_b0;
    assign o_b1 = r_b1;
    assign o_b2 = r_b2;
    assign o_a1 = r_a1;
    assign o_a2 = r_a2;

endmodule
